>>> rtl/core/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Token and scan mode types, keyword table and queue sizing shared by the
// streaming token scanner modules.
// ----------------------------------------------------------------------------
package tsc_pkg;

	// Default offset counter width
	localparam int TSC_OFFSET_WIDTH = 16;

	// Token queue depth (power of two, at least two)
	localparam int TQ_DEPTH = 4;
	localparam int TQ_AW    = $clog2(TQ_DEPTH);
	localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

	// Token types as seen on token_type
	typedef enum logic [4:0] {
		TOK_IDENT, TOK_NUMBER, TOK_STRING, TOK_ASSIGN, TOK_SEMI, TOK_COLON,
		TOK_COMMA, TOK_LPAR, TOK_RPAR, TOK_PLUS, TOK_MINUS, TOK_MUL, TOK_DIV,
		TOK_RAISE, TOK_LT, TOK_EQ, TOK_GT, TOK_LE, TOK_GE, TOK_NE,
		TOK_PRINT, TOK_IF, TOK_ELSE, TOK_ENDIF, TOK_SQRT, TOK_AND, TOK_OR,
		TOK_NOT, TOK_EOF, TOK_ERR
	} tok_type_t;

	// Scan modes
	typedef enum logic [3:0] {
		MODE_IDLE, MODE_IDENT, MODE_INT, MODE_DOT, MODE_FRAC, MODE_EXPE,
		MODE_ESIGN, MODE_EXP, MODE_STR, MODE_CMT, MODE_COLON, MODE_STAR,
		MODE_LT, MODE_GT, MODE_BANG, MODE_SLASH
	} scan_mode_t;

	// One emitted token
	typedef struct packed {
		logic        vld;
		tok_type_t   typ;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} tok_t;

	// Tokens produced by one input item, in emission order
	typedef struct packed {
		tok_t t0;
		tok_t t1;
	} tsc_run_t;

	// Keyword table: packed uppercase text, length and token type
	localparam logic [39:0] KW_TEXT [8] = '{
		40'h5052494E54, 40'h0000004946, 40'h00454C5345, 40'h454E444946,
		40'h0053515254, 40'h0000414E44, 40'h0000004F52, 40'h00004E4F54
	};
	localparam logic [2:0] KW_LEN [8] = '{
		3'd5, 3'd2, 3'd4, 3'd5, 3'd4, 3'd3, 3'd2, 3'd3
	};
	localparam tok_type_t KW_TOK [8] = '{
		TOK_PRINT, TOK_IF, TOK_ELSE, TOK_ENDIF,
		TOK_SQRT, TOK_AND, TOK_OR, TOK_NOT
	};

	// Word type from the first five characters and the word length
	// (length 0 stands for any length that cannot be a keyword)
	function automatic tok_type_t kw_match(input logic [39:0] win, input logic [2:0] n);
		tok_type_t r;
		r = TOK_IDENT;
		for (int k = 0; k < 8; k++) begin
			if (n == KW_LEN[k] && win == KW_TEXT[k]) begin
				r = KW_TOK[k];
			end
		end
		return r;
	endfunction

endpackage

>>> rtl/core/tsc_lexer.sv
// ----------------------------------------------------------------------------
// Token scanner lexer core
// Holds the scan state and turns the registered input byte into zero, one
// or two tokens in a single combinational step.
// ----------------------------------------------------------------------------
module tsc_lexer import tsc_pkg::*; #(
	parameter int OFFSET_WIDTH = TSC_OFFSET_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] ch,
	input  logic       eoi,
	output tsc_run_t   run
);

	localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;
	localparam logic [OFFSET_WIDTH-1:0] LEN5    = OFFSET_WIDTH'(5);
	localparam logic [OFFSET_WIDTH-1:0] LEN8    = OFFSET_WIDTH'(8);

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_LC_E  = 8'h65;

	scan_mode_t              mode_q, mode_d;
	logic [OFFSET_WIDTH-1:0] tb_q, tb_d;
	logic [OFFSET_WIDTH-1:0] off_q, off_d;
	logic [39:0]             win_q, win_d;

	logic [OFFSET_WIDTH-1:0] nxt, len_cur, len_nxt;
	logic [2:0]              kw_n;
	logic                    is_letter, is_digit, is_space, is_e;
	logic                    absorbed;
	tok_t                    fl, e0, e1;

	// Byte classes and offsets
	assign is_letter = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)
		|| ch == 8'h5F;
	assign is_digit  = ch >= 8'h30 && ch <= 8'h39;
	assign is_space  = ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
	assign is_e      = ch == CH_LC_E || ch == CH_UC_E;
	assign nxt       = (off_q != OFS_MAX) ? off_q + 1'b1 : off_q;
	assign len_cur   = off_q - tb_q;
	assign len_nxt   = nxt - tb_q;
	assign kw_n      = (len_cur < LEN8) ? len_cur[2:0] : 3'd0;

	// Token that closes the current mode, ending just before the current byte
	always_comb begin
		fl       = '0;
		fl.vld   = 1'b1;
		fl.start = 16'(tb_q);
		fl.len   = 16'(len_cur);
		fl.typ   = TOK_ERR;
		case (mode_q)
			MODE_IDENT: fl.typ = kw_match(win_q, kw_n);
			MODE_INT, MODE_FRAC, MODE_EXP: fl.typ = TOK_NUMBER;
			MODE_DOT, MODE_EXPE, MODE_ESIGN, MODE_STR: fl.typ = TOK_ERR;
			MODE_COLON: begin
				fl.typ = TOK_COLON;
				fl.len = 16'd1;
			end
			MODE_STAR: begin
				fl.typ = TOK_MUL;
				fl.len = 16'd1;
			end
			MODE_LT: begin
				fl.typ = TOK_LT;
				fl.len = 16'd1;
			end
			MODE_GT: begin
				fl.typ = TOK_GT;
				fl.len = 16'd1;
			end
			MODE_BANG: begin
				fl.typ = TOK_ERR;
				fl.len = 16'd1;
			end
			MODE_SLASH: begin
				fl.typ = TOK_DIV;
				fl.len = 16'd1;
			end
			default: fl.vld = 1'b0;
		endcase
	end

	// Next state and emitted tokens
	always_comb begin
		mode_d   = mode_q;
		tb_d     = tb_q;
		off_d    = off_q;
		win_d    = win_q;
		e0       = '0;
		e1       = '0;
		absorbed = 1'b0;
		if (eoi) begin
			e0       = fl;
			e1.vld   = 1'b1;
			e1.typ   = TOK_EOF;
			e1.start = 16'(off_q);
			e1.len   = 16'd0;
			mode_d   = MODE_IDLE;
			tb_d     = '0;
			off_d    = '0;
			win_d    = '0;
		end else begin
			// continue the open token
			unique case (mode_q)
				MODE_IDLE: absorbed = 1'b0;
				MODE_IDENT: begin
					if (is_letter || is_digit) begin
						absorbed = 1'b1;
						if (len_cur < LEN5) begin
							win_d = {win_q[31:0], ch};
						end
					end
				end
				MODE_INT: begin
					if (is_digit) begin
						absorbed = 1'b1;
					end else if (ch == CH_DOT) begin
						absorbed = 1'b1;
						mode_d   = MODE_DOT;
					end else if (is_e) begin
						absorbed = 1'b1;
						mode_d   = MODE_EXPE;
					end
				end
				MODE_DOT: begin
					if (is_digit) begin
						absorbed = 1'b1;
						mode_d   = MODE_FRAC;
					end
				end
				MODE_FRAC: begin
					if (is_digit) begin
						absorbed = 1'b1;
					end else if (is_e) begin
						absorbed = 1'b1;
						mode_d   = MODE_EXPE;
					end
				end
				MODE_EXPE: begin
					if (ch == CH_PLUS || ch == CH_MINUS) begin
						absorbed = 1'b1;
						mode_d   = MODE_ESIGN;
					end else if (is_digit) begin
						absorbed = 1'b1;
						mode_d   = MODE_EXP;
					end
				end
				MODE_ESIGN: begin
					if (is_digit) begin
						absorbed = 1'b1;
						mode_d   = MODE_EXP;
					end
				end
				MODE_EXP: absorbed = is_digit;
				MODE_STR: begin
					if (ch == CH_QUOTE) begin
						absorbed = 1'b1;
						e0.vld   = 1'b1;
						e0.typ   = TOK_STRING;
						e0.start = 16'(tb_q);
						e0.len   = 16'(len_nxt);
						mode_d   = MODE_IDLE;
					end else if (ch != CH_LF) begin
						absorbed = 1'b1;
					end
				end
				MODE_CMT: begin
					absorbed = 1'b1;
					if (ch == CH_LF) begin
						mode_d = MODE_IDLE;
					end
				end
				MODE_SLASH: begin
					if (ch == CH_SLASH) begin
						absorbed = 1'b1;
						mode_d   = MODE_CMT;
					end
				end
				MODE_COLON, MODE_STAR, MODE_LT, MODE_GT, MODE_BANG: begin
					// two-character operators
					e0.start = 16'(tb_q);
					e0.len   = 16'd2;
					if (mode_q == MODE_COLON && ch == CH_EQ) begin
						e0.typ = TOK_ASSIGN;
						e0.vld = 1'b1;
					end else if (mode_q == MODE_STAR && ch == CH_STAR) begin
						e0.typ = TOK_RAISE;
						e0.vld = 1'b1;
					end else if (mode_q == MODE_LT && ch == CH_EQ) begin
						e0.typ = TOK_LE;
						e0.vld = 1'b1;
					end else if (mode_q == MODE_GT && ch == CH_EQ) begin
						e0.typ = TOK_GE;
						e0.vld = 1'b1;
					end else if (mode_q == MODE_BANG && ch == CH_EQ) begin
						e0.typ = TOK_NE;
						e0.vld = 1'b1;
					end
					if (e0.vld) begin
						absorbed = 1'b1;
						mode_d   = MODE_IDLE;
					end
				end
			endcase

			// close the open token and start a new one with this byte
			if (!absorbed) begin
				e0       = fl;
				mode_d   = MODE_IDLE;
				e1.start = 16'(off_q);
				e1.len   = 16'd1;
				e1.typ   = TOK_ERR;
				if (is_space) begin
					e1.vld = 1'b0;
				end else if (is_letter) begin
					mode_d = MODE_IDENT;
					tb_d   = off_q;
					win_d  = {32'd0, ch};
				end else if (is_digit) begin
					mode_d = MODE_INT;
					tb_d   = off_q;
				end else if (ch == CH_QUOTE) begin
					mode_d = MODE_STR;
					tb_d   = off_q;
				end else if (ch == CH_COLON) begin
					mode_d = MODE_COLON;
					tb_d   = off_q;
				end else if (ch == CH_STAR) begin
					mode_d = MODE_STAR;
					tb_d   = off_q;
				end else if (ch == CH_LT) begin
					mode_d = MODE_LT;
					tb_d   = off_q;
				end else if (ch == CH_GT) begin
					mode_d = MODE_GT;
					tb_d   = off_q;
				end else if (ch == CH_BANG) begin
					mode_d = MODE_BANG;
					tb_d   = off_q;
				end else if (ch == CH_SLASH) begin
					mode_d = MODE_SLASH;
					tb_d   = off_q;
				end else begin
					// single-character tokens and stray bytes
					e1.vld = 1'b1;
					case (ch)
						CH_SEMI:  e1.typ = TOK_SEMI;
						CH_COMMA: e1.typ = TOK_COMMA;
						CH_LPAR:  e1.typ = TOK_LPAR;
						CH_RPAR:  e1.typ = TOK_RPAR;
						CH_PLUS:  e1.typ = TOK_PLUS;
						CH_MINUS: e1.typ = TOK_MINUS;
						CH_EQ:    e1.typ = TOK_EQ;
						default:  e1.typ = TOK_ERR;
					endcase
				end
			end
			off_d = nxt;
		end
	end

	// Pack emitted tokens in order and mark the last one
	always_comb begin
		run.t0      = e0.vld ? e0 : e1;
		run.t1      = e0.vld ? e1 : '0;
		run.t0.last = !(e0.vld && e1.vld);
		run.t1.last = 1'b1;
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			tb_q   <= '0;
			off_q  <= '0;
			win_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			tb_q   <= tb_d;
			off_q  <= off_d;
			win_q  <= win_d;
		end
	end

	// A second token never comes without a first
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		run.t1.vld |-> run.t0.vld)
		else $error("second token without a first");

	// End marker restarts the scan at offset zero in idle mode
	a_eoi_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eoi |=> off_q == '0 && mode_q == MODE_IDLE)
		else $error("end marker did not restart the scan");

	// Offset only grows between end markers
	a_off_mono: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !eoi |=> off_q >= $past(off_q))
		else $error("offset went backward");

	// A token start never lies beyond the current offset
	a_tb_le_off: assert property (@(posedge clk) disable iff (!arst_n)
		tb_q <= off_q)
		else $error("token start past offset");

endmodule

>>> rtl/core/tsc_tok_queue.sv
// ----------------------------------------------------------------------------
// Token scanner output queue
// Small register queue that takes up to two tokens a cycle from the lexer
// and hands one token per transaction to the output channel.
// ----------------------------------------------------------------------------
module tsc_tok_queue import tsc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tsc_run_t run,
	input  logic     pop,
	output tok_t     head,
	output logic     valid,
	output logic     room
);

	tok_t             mem_q [TQ_DEPTH];
	logic [TQ_AW-1:0] wr_q, rd_q;
	logic [TQ_CW-1:0] count_q;
	logic [1:0]       n_push;
	logic             do_pop;

	// Occupancy
	assign valid  = count_q != '0;
	assign room   = count_q <= TQ_CW'(TQ_DEPTH - 2);
	assign do_pop = pop && valid;
	assign n_push = push ? ({1'b0, run.t0.vld} + {1'b0, run.t1.vld}) : 2'd0;
	assign head   = mem_q[rd_q];

	// Token storage
	always_ff @(posedge clk) begin
		if (push && run.t0.vld) begin
			mem_q[wr_q] <= run.t0;
		end
		if (push && run.t1.vld) begin
			mem_q[wr_q + 1'b1] <= run.t1;
		end
	end

	// Pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + TQ_AW'(n_push);
			rd_q    <= rd_q + TQ_AW'(do_pop);
			count_q <= count_q + TQ_CW'(n_push) - TQ_CW'(do_pop);
		end
	end

	// Never more tokens held than slots
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= TQ_CW'(TQ_DEPTH))
		else $error("token queue overflow");

	// A push only happens with room for a full run
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q <= TQ_CW'(TQ_DEPTH - 2))
		else $error("push without room for two tokens");

	// Read pointer only moves on a pop
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!do_pop |=> $stable(rd_q))
		else $error("read pointer moved without a pop");

endmodule

>>> rtl/core/streaming_token_scanner_top.sv
// ----------------------------------------------------------------------------
// Streaming token scanner
// Byte-serial lexer: one text byte or end marker per input transaction,
// one token per output transaction.
// ----------------------------------------------------------------------------
// Path: input register, then the lexer step writes the token queue for output.
// Throughput: one input item per cycle while the token queue has room for
//   a full run; an item that closes two tokens needs two output
//   transactions, so the output port bounds the sustained rate.
// Reset: arst_n clears the scan state to idle at offset zero and empties the
//   input register and the four-entry token queue.
module streaming_token_scanner_top import tsc_pkg::*; #(
	parameter int OFFSET_WIDTH = TSC_OFFSET_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_type,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       eoi_s1;
	logic       room;
	logic       fire;
	tsc_run_t   run;
	tok_t       head;

	// Input stage advances when the queue can take a full run
	assign fire     = vld_s1 && room;
	assign in_stall = vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1  <= ch;
			eoi_s1 <= end_of_input;
		end
	end

	// Lexer step
	tsc_lexer #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (ch_s1),
		.eoi    (eoi_s1),
		.run    (run)
	);

	// Token queue toward the output channel
	tsc_tok_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.run    (run),
		.pop    (!out_stall),
		.head   (head),
		.valid  (out_valid),
		.room   (room)
	);

	assign token_type   = head.typ;
	assign token_start  = head.start;
	assign token_length = head.len;
	assign last_of_run  = head.last;

endmodule
